// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file nrte_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define NRTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define NRTE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/nrte_pkg.sv -----
package nrte_pkg;

    // Sentence scanner phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_JUNK,
        PH_START,
        PH_PAYLOAD,
        PH_HEX,
        PH_TRAIL
    } phase_t;

    // Verdict codes on the result channel
    typedef enum logic [2:0] {
        REJ_OK        = 3'd0,
        REJ_CKSUM     = 3'd1,
        REJ_HEADER    = 3'd2,
        REJ_STATUS    = 3'd3,
        REJ_MALFORMED = 3'd4
    } reject_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [4:0] TZ_RESET  = 5'd8;
    localparam logic [4:0] HOURS_DAY = 5'd24;

    // Verdict of one finished sentence plus the UTC time it carried
    typedef struct packed {
        logic       fire;
        reject_t    code;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } parse_res_t;

    // Expected header text "$GPRMC", by character position
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h57);
        else
            v = 4'(c - 8'h37);
        return v;
    endfunction

    // Two decimal digits to a binary value (0..99 for valid digits)
    function automatic logic [6:0] dec2(input logic [3:0] d1, input logic [3:0] d0);
        return 7'(7'(d1) * 7'd10 + 7'(d0));
    endfunction

endpackage

// ----- rtl/core/nrte_parser.sv -----
module nrte_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          char_in,
    output nrte_pkg::parse_res_t res
);
    import nrte_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] cks_reg, cks_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [1:0]  fnum_reg, fnum_next;
    logic [2:0]  fpos_reg, fpos_next;
    logic        hmis_reg, hmis_next;
    logic        stat_reg, stat_next;
    logic        malf_reg, malf_next;
    logic [3:0]  dig_reg [6];
    logic [3:0]  dig_next [6];

    logic        is_ws;
    logic [6:0]  hh, mm, ss;
    logic        digits_bad;
    reject_t     fin_code;

    assign is_ws = (char_in == CH_CR) || (char_in == CH_LF) ||
                   (char_in == CH_SPACE) || (char_in == CH_TAB);

    // Time digits of field 1 as binary values
    assign hh = dec2(dig_reg[0], dig_reg[1]);
    assign mm = dec2(dig_reg[2], dig_reg[3]);
    assign ss = dec2(dig_reg[4], dig_reg[5]);

    always_comb
    begin
        digits_bad = 1'b0;
        for (int k = 0; k < 6; k++)
        begin
            if (dig_reg[k] > 4'd9)
                digits_bad = 1'b1;
        end
    end

    // Verdict on the sentence ending now, checks in priority order
    always_comb
    begin
        if (phase_reg == PH_JUNK || malf_reg || phase_reg == PH_START ||
            phase_reg == PH_PAYLOAD || (phase_reg == PH_HEX && dcnt_reg == 3'd0))
            fin_code = REJ_MALFORMED;
        else if (cks_reg != {8'h00, xor_reg})
            fin_code = REJ_CKSUM;
        else if (hmis_reg || (fnum_reg == 2'd0 && fpos_reg < 3'd6))
            fin_code = REJ_HEADER;
        else if (!(fnum_reg == 2'd3 || (fnum_reg == 2'd2 && fpos_reg != 3'd0)))
            fin_code = REJ_MALFORMED;
        else if (!stat_reg)
            fin_code = REJ_STATUS;
        else if (digits_bad || hh > 7'd23 || mm > 7'd59 || ss > 7'd59)
            fin_code = REJ_MALFORMED;
        else
            fin_code = REJ_OK;
    end

    // Result toward the time keeper
    always_comb
    begin
        res.fire   = step_en && is_ws && (phase_reg != PH_IDLE);
        res.code   = fin_code;
        res.hour   = hh[4:0];
        res.minute = mm[5:0];
        res.second = ss[5:0];
    end

    // Scanner next state
    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        cks_next   = cks_reg;
        dcnt_next  = dcnt_reg;
        fnum_next  = fnum_reg;
        fpos_next  = fpos_reg;
        hmis_next  = hmis_reg;
        stat_next  = stat_reg;
        malf_next  = malf_reg;
        for (int k = 0; k < 6; k++)
            dig_next[k] = dig_reg[k];

        if (step_en)
        begin
            if (is_ws)
            begin
                phase_next = PH_IDLE;
            end
            else if (phase_reg == PH_IDLE)
            begin
                if (char_in == CH_DOLLAR)
                begin
                    phase_next = PH_START;
                    xor_next   = 8'h00;
                    cks_next   = 16'h0000;
                    dcnt_next  = 3'd0;
                    fnum_next  = 2'd0;
                    fpos_next  = 3'd1;
                    hmis_next  = 1'b0;
                    stat_next  = 1'b0;
                    malf_next  = 1'b0;
                    for (int k = 0; k < 6; k++)
                        dig_next[k] = 4'hF;
                end
                else
                begin
                    phase_next = PH_JUNK;
                end
            end
            else if (phase_reg != PH_JUNK)
            begin
                if (char_in == CH_NUL)
                    malf_next = 1'b1;

                // checksum section
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (char_in == CH_STAR)
                        begin
                            malf_next  = 1'b1;
                            phase_next = PH_HEX;
                        end
                        else
                        begin
                            xor_next   = xor_reg ^ char_in;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (char_in == CH_STAR)
                            phase_next = PH_HEX;
                        else
                            xor_next = xor_reg ^ char_in;
                    end
                    PH_HEX:
                    begin
                        if (is_hex(char_in))
                        begin
                            if (cks_reg > 16'h0FFF)
                                cks_next = 16'hFFFF;
                            else
                                cks_next = {cks_reg[11:0], hex_val(char_in)};
                            if (dcnt_reg < 3'd7)
                                dcnt_next = dcnt_reg + 3'd1;
                        end
                        else
                        begin
                            if (dcnt_reg == 3'd0)
                                malf_next = 1'b1;
                            phase_next = PH_TRAIL;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // comma field tracking, empty fields collapse
                if (char_in == CH_COMMA)
                begin
                    if (fpos_reg != 3'd0)
                    begin
                        if (fnum_reg == 2'd0 && fpos_reg < 3'd6)
                            hmis_next = 1'b1;
                        if (fnum_reg < 2'd3)
                            fnum_next = fnum_reg + 2'd1;
                        fpos_next = 3'd0;
                    end
                end
                else
                begin
                    if (fnum_reg == 2'd0)
                    begin
                        if (fpos_reg >= 3'd6 || char_in != hdr_char(fpos_reg))
                            hmis_next = 1'b1;
                    end
                    else if (fnum_reg == 2'd1 && fpos_reg < 3'd6)
                    begin
                        for (int k = 0; k < 6; k++)
                        begin
                            if (fpos_reg == 3'(k))
                                dig_next[k] = (char_in >= 8'h30 && char_in <= 8'h39) ?
                                              char_in[3:0] : 4'hF;
                        end
                    end
                    else if (fnum_reg == 2'd2 && fpos_reg == 3'd0)
                    begin
                        stat_next = (char_in == CH_A);
                    end
                    if (fpos_reg < 3'd7)
                        fpos_next = fpos_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            xor_reg   <= 8'h00;
            cks_reg   <= 16'h0000;
            dcnt_reg  <= 3'd0;
            fnum_reg  <= 2'd0;
            fpos_reg  <= 3'd0;
            hmis_reg  <= 1'b0;
            stat_reg  <= 1'b0;
            malf_reg  <= 1'b0;
            for (int k = 0; k < 6; k++)
                dig_reg[k] <= 4'h0;
        end
        else
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            cks_reg   <= cks_next;
            dcnt_reg  <= dcnt_next;
            fnum_reg  <= fnum_next;
            fpos_reg  <= fpos_next;
            hmis_reg  <= hmis_next;
            stat_reg  <= stat_next;
            malf_reg  <= malf_next;
            for (int k = 0; k < 6; k++)
                dig_reg[k] <= dig_next[k];
        end
    end

endmodule

// ----- rtl/core/nrte_clock.sv -----
module nrte_clock (
    input  logic                clk,
    input  logic                rst_n,
    input  nrte_pkg::parse_res_t res,
    input  logic [4:0]          tz_hours,
    output logic                held_next,
    output logic [4:0]          hour_next,
    output logic [5:0]          minute_next,
    output logic [5:0]          second_next
);
    import nrte_pkg::*;

    logic       held_reg;
    logic [4:0] hour_reg;
    logic [5:0] minute_reg, second_reg;
    logic [4:0] tz_adj;
    logic [5:0] hour_sum;
    logic [4:0] local_hr;
    logic       take;

    // Offset reduced to 0..23, then one wrap of the sum
    assign tz_adj   = (tz_hours >= HOURS_DAY) ? 5'(tz_hours - HOURS_DAY) : tz_hours;
    assign hour_sum = 6'(res.hour) + 6'(tz_adj);
    assign local_hr = (hour_sum >= 6'(HOURS_DAY)) ? 5'(hour_sum - 6'(HOURS_DAY))
                                                 : hour_sum[4:0];
    assign take     = res.fire && (res.code == REJ_OK);

    // Latest accepted time, old value kept on a rejected sentence
    always_comb
    begin
        held_next   = held_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (take)
        begin
            held_next   = 1'b1;
            hour_next   = local_hr;
            minute_next = res.minute;
            second_next = res.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= 1'b0;
            hour_reg   <= 5'd0;
            minute_reg <= 6'd0;
            second_reg <= 6'd0;
        end
        else
        begin
            held_reg   <= held_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

endmodule

// ----- rtl/core/nmea_rmc_time_extractor.sv -----
// A character beat reaches its result beat through the input register and then the result register.
// Throughput: one character per cycle when the result is not stalled; scanner state updates once per character.
// A character ending a sentence yields one result beat; others yield none.
// Stall: the input register holds while an unaccepted result blocks the result register.
// Reset (rst_n low, async): scanner idle, no time held, offset 8 hours.
module nmea_rmc_time_extractor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] tz_offset_hours,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       sentence_valid,
    output logic [2:0] reject_code,
    output logic       time_held,
    output logic [4:0] local_hour,
    output logic [5:0] local_minute,
    output logic [5:0] local_second
);
    import nrte_pkg::*;

    logic       tz_we;
    logic [4:0] tz_val_reg;
    logic       in_vld_reg;
    logic [7:0] char_reg;
    logic       advance, step_en;
    parse_res_t res;
    logic       held_next;
    logic [4:0] hour_next;
    logic [5:0] minute_next, second_next;

    logic       out_vld_reg;
    logic       sv_reg;
    logic [2:0] code_reg;
    logic       held_reg;
    logic [4:0] hour_reg;
    logic [5:0] minute_reg, second_reg;

    assign tz_we     = cfg_valid;
    assign cfg_ready = 1'b1;

    // Offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tz_val_reg <= TZ_RESET;
        else if (tz_we)
            tz_val_reg <= tz_offset_hours;
    end

    // Stage handshake
    assign advance  = !out_vld_reg || out_ready;
    assign step_en  = in_vld_reg && advance;
    assign in_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            char_reg <= char_byte;
    end

    nrte_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .char_in (char_reg),
        .res     (res)
    );

    nrte_clock u_clock (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .tz_hours    (tz_val_reg),
        .held_next   (held_next),
        .hour_next   (hour_next),
        .minute_next (minute_next),
        .second_next (second_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= res.fire;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.fire)
        begin
            sv_reg     <= (res.code == REJ_OK);
            code_reg   <= res.code;
            held_reg   <= held_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign sentence_valid = sv_reg;
    assign reject_code    = code_reg;
    assign time_held      = held_reg;
    assign local_hour     = hour_reg;
    assign local_minute   = minute_reg;
    assign local_second   = second_reg;

endmodule

// ----- rtl/core/nrte_checker.sv -----
`include "assert_macros.svh"

module nrte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       sentence_valid,
    input logic [2:0] reject_code,
    input logic       time_held,
    input logic [4:0] local_hour,
    input logic [5:0] local_minute,
    input logic [5:0] local_second
);
    import nrte_pkg::*;

    // A stalled result beat stays put
    `NRTE_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(reject_code),
                     "result beat dropped or changed while stalled")

    // Verdict flag agrees with the code
    `NRTE_ASSERT_IMP(a_ok_code, out_valid, sentence_valid == (reject_code == REJ_OK),
                     "sentence_valid disagrees with reject_code")

    // An accepted sentence always leaves a time held
    `NRTE_ASSERT_IMP(a_ok_held, out_valid && sentence_valid, time_held,
                     "accepted sentence without held time")

    // Reported time is in range
    `NRTE_ASSERT_IMP(a_range, out_valid,
                     local_hour < 5'd24 && local_minute < 6'd60 && local_second < 6'd60,
                     "local time out of range")

    // Nothing held means a zero time
    `NRTE_ASSERT_IMP(a_zero, out_valid && !time_held,
                     local_hour == 5'd0 && local_minute == 6'd0 && local_second == 6'd0,
                     "time reported before any capture")

endmodule

bind nmea_rmc_time_extractor nrte_checker u_nrte_checker (.*);
